// ===== rtl/spk_pkg.sv =====
// spk_pkg: shared constants, types and round functions for the speck 64/128 cipher
// no dependencies; used by the interfaces, key schedule, round stage and top level

package spk_pkg;

  localparam int ROUNDS    = 27;
  localparam int WORD_W    = 32;
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int KEY_WORDS = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(3);

  // mode codes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROUNDS-1:0][WORD_W-1:0] rk_array_t;

  // one pipeline slot: valid bit travels with the block
  typedef struct packed {
    logic  valid;
    logic  mode;
    word_t x;
    word_t y;
  } stage_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

// ===== rtl/spk_if.sv =====
// spk_in_if / spk_out_if: valid-ready channels for blocks into and out of the cipher
// depends on spk_pkg for the word type

interface spk_in_if
  import spk_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t in_word_lo;
  word_t in_word_hi;

  modport source (output valid, mode, in_word_lo, in_word_hi, input ready);
  modport sink   (input valid, mode, in_word_lo, in_word_hi, output ready);
endinterface

interface spk_out_if
  import spk_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t out_word_lo;
  word_t out_word_hi;

  modport source (output valid, out_word_lo, out_word_hi, input ready);
  modport sink   (input valid, out_word_lo, out_word_hi, output ready);
endinterface

// ===== rtl/spk_key_sched.sv =====
// spk_key_sched: key registers and iterative expansion into the round-key store
// depends on spk_pkg

module spk_key_sched
  import spk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data,
  output rk_array_t            round_keys,
  output logic                 keys_ready
);

  word_t            key_word [KEY_WORDS];
  logic             running;
  logic [RND_W-1:0] rnd;
  word_t            k;
  word_t            l0;
  word_t            l1;
  word_t            l2;
  word_t            l_next;
  logic             key_write;

  // a write to an unknown index is dropped
  assign key_write = cfg_we && (cfg_index inside {REG_KEY_WORD_0, REG_KEY_WORD_1,
                                                  REG_KEY_WORD_2, REG_KEY_WORD_3});

  assign l_next = (rotr(l0, 8) + k) ^ WORD_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
    end else if (key_write) begin
      key_word[cfg_index[$clog2(KEY_WORDS)-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      keys_ready <= 1'b0;
      rnd        <= '0;
    end else if (key_write) begin
      running    <= 1'b0;
      keys_ready <= 1'b0;
    end else if (!keys_ready && !running) begin
      running <= 1'b1;
      rnd     <= '0;
    end else if (running) begin
      rnd <= rnd + RND_W'(1);
      if (rnd == LAST_ROUND) begin
        running    <= 1'b0;
        keys_ready <= 1'b1;
      end
    end
  end

  // the three l words rotate through l0 so l0 is always l[i mod 3]
  always_ff @(posedge clk) begin
    if (!keys_ready && !running) begin
      k  <= key_word[0];
      l0 <= key_word[1];
      l1 <= key_word[2];
      l2 <= key_word[3];
    end else if (running) begin
      round_keys[rnd] <= k;
      k  <= rotl(k, 3) ^ l_next;
      l0 <= l1;
      l1 <= l2;
      l2 <= l_next;
    end
  end

endmodule

// ===== rtl/spk_round.sv =====
// spk_round: one registered round of the cipher, encrypt or decrypt per item
// depends on spk_pkg

module spk_round
  import spk_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  stage_t d,
  input  word_t  rk_enc,
  input  word_t  rk_dec,
  output stage_t q
);

  word_t x_enc;
  word_t y_enc;
  word_t x_dec;
  word_t y_dec;

  assign x_enc = (rotr(d.x, 8) + d.y) ^ rk_enc;
  assign y_enc = rotl(d.y, 3) ^ x_enc;
  assign y_dec = rotr(d.y ^ d.x, 3);
  assign x_dec = rotl((d.x ^ rk_dec) - y_dec, 8);

  // only the valid bit is reset, the block words follow it
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.mode <= d.mode;
      if (d.mode == MODE_DECRYPT) begin
        q.x <= x_dec;
        q.y <= y_dec;
      end else begin
        q.x <= x_enc;
        q.y <= y_enc;
      end
    end
  end

endmodule

// ===== rtl/speck64_128_block_cipher_top.sv =====
// speck64_128_block_cipher_top: speck 64/128 ecb cipher, 27-stage round pipeline
// depends on spk_pkg, spk_if, spk_key_sched and spk_round

// Speck 64/128 in ECB fashion. Each block passes through 27 round stages, one
// round per register stage, and a new block can be taken every cycle while the
// output is not held back and the keys are ready. Encrypt and decrypt items
// may be mixed freely. When the output is held back the whole pipeline holds,
// and nothing is lost or repeated. After reset, and after any write to a key
// word, the round keys are rebuilt by an iterative schedule at one key per
// cycle, one load step then 27 round steps, during which no block is taken.
// Key words are meant to be written only while no block is in flight.

module speck64_128_block_cipher_top
  import spk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data,
  spk_in_if.sink               blk_in,
  spk_out_if.source            blk_out
);

  rk_array_t round_keys;
  logic      keys_ready;
  logic      advance;
  stage_t    stage [ROUNDS+1];

  // key registers and round-key schedule
  spk_key_sched u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .keys_ready (keys_ready)
  );

  // pipeline moves as one unless a finished item is waiting at the output
  assign advance      = !stage[ROUNDS].valid || blk_out.ready;
  assign blk_in.ready = advance && keys_ready;

  // entry slot: holds an item only when it is accepted
  assign stage[0].valid = blk_in.valid && blk_in.ready;
  assign stage[0].mode  = blk_in.mode;
  assign stage[0].x     = blk_in.in_word_hi;
  assign stage[0].y     = blk_in.in_word_lo;

  // stage s runs encrypt round s or decrypt round ROUNDS-1-s
  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    spk_round u_round (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .d      (stage[s]),
      .rk_enc (round_keys[s]),
      .rk_dec (round_keys[ROUNDS-1-s]),
      .q      (stage[s+1])
    );
  end

  // the last stage doubles as the output register
  assign blk_out.valid       = stage[ROUNDS].valid;
  assign blk_out.out_word_lo = stage[ROUNDS].y;
  assign blk_out.out_word_hi = stage[ROUNDS].x;

endmodule

// ===== verif/tb_speck64_128_block_cipher_top.sv =====
`timescale 1ns / 100ps
// tb_speck64_128_block_cipher_top: self-checking testbench for the speck 64/128 ecb cipher
// depends on spk_pkg, spk_in_if / spk_out_if and speck64_128_block_cipher_top

module tb_speck64_128_block_cipher_top;
  import spk_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int SEGMENTS     = 8;
  localparam int DRAIN_CYCLES = ROUNDS + 8;  // pipeline depth plus margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;
  localparam int MAX_GAP      = 200;
  localparam int KEY_IDX_W    = $clog2(KEY_WORDS);
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

  // published speck 64/128 test vector
  localparam word_t KAT_K0 = 32'h03020100;
  localparam word_t KAT_K1 = 32'h0b0a0908;
  localparam word_t KAT_K2 = 32'h13121110;
  localparam word_t KAT_K3 = 32'h1b1a1918;
  localparam word_t KAT_PT_HI = 32'h3b726574;
  localparam word_t KAT_PT_LO = 32'h7475432d;
  localparam word_t KAT_CT_HI = 32'h8c6fa548;
  localparam word_t KAT_CT_LO = 32'h454e028b;

  typedef struct packed {
    word_t lo;
    word_t hi;
  } block_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  spk_in_if  blk_in_ch ();
  spk_out_if blk_out_ch ();

  speck64_128_block_cipher_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_in    (blk_in_ch),
    .blk_out   (blk_out_ch)
  );

  // mirror of the key registers and the expanded schedule
  word_t  key_reg [KEY_WORDS];
  word_t  sched_key [ROUNDS];
  logic   sched_valid;

  // blocks still owed by the cipher, oldest first
  block_t expected_blocks [$];

  int idle_pct;
  int stall_pct;
  int cycle_count;
  int fail_count;
  int items_sent;
  int blocks_checked;
  int key_loads;

  // clock: 20 ns period
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped: no progress after %0d cycles, %0d blocks outstanding",
               cycle_count, expected_blocks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  // key expansion: running word k, three mixed words l
  function automatic void expand_schedule();
    word_t k;
    word_t l [3];
    int    j;
    k = key_reg[0];
    for (int i = 0; i < 3; i++) begin
      l[i] = key_reg[i + 1];
    end
    for (int i = 0; i < ROUNDS; i++) begin
      j = i % 3;
      sched_key[i] = k;
      l[j] = ({l[j][7:0], l[j][31:8]} + k) ^ word_t'(i);
      k = {k[28:0], k[31:29]} ^ l[j];
    end
    sched_valid = 1'b1;
  endfunction

  // the whole 27-round transform of one block in either direction
  function automatic block_t cipher_block(logic mode, word_t lo, word_t hi);
    word_t x;
    word_t y;
    x = hi;
    y = lo;
    if (!sched_valid) begin
      expand_schedule();
    end
    if (mode == MODE_ENCRYPT) begin
      for (int r = 0; r < ROUNDS; r++) begin
        x = ({x[7:0], x[31:8]} + y) ^ sched_key[r];
        y = {y[28:0], y[31:29]} ^ x;
      end
    end else begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        y = y ^ x;
        y = {y[2:0], y[31:3]};
        x = (x ^ sched_key[r]) - y;
        x = {x[23:0], x[31:24]};
      end
    end
    return '{lo: y, hi: x};
  endfunction

  // mostly uniform words, with corner values mixed in
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WORD_W - 1);
      3:       return ~(word_t'(1) << $urandom_range(WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  // one block into the cipher; valid stays high after acceptance so that
  // back-to-back items never see it dip within a step
  task automatic send_block(logic mode, word_t lo, word_t hi);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    @(negedge clk);
    repeat (gap) begin
      blk_in_ch.valid = 1'b0;
      @(negedge clk);
    end
    blk_in_ch.valid      = 1'b1;
    blk_in_ch.mode       = mode;
    blk_in_ch.in_word_lo = lo;
    blk_in_ch.in_word_hi = hi;
    do begin
      @(posedge clk);
    end while (!blk_in_ch.ready);
    expected_blocks.push_back(cipher_block(mode, lo, hi));
    items_sent++;
  endtask

  // drop valid, let every owed block come out, then let the pipe settle
  task automatic drain_pipeline();
    @(negedge clk);
    blk_in_ch.valid = 1'b0;
    while (expected_blocks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, word_t data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
    // unknown indexes leave the key and its schedule alone
    if (index < KEY_WORDS) begin
      key_reg[index[KEY_IDX_W-1:0]] = data;
      sched_valid                   = 1'b0;
    end
  endtask

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    drain_pipeline();
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_1, k1);
    write_reg(REG_KEY_WORD_2, k2);
    write_reg(REG_KEY_WORD_3, k3);
    key_loads++;
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    block_t want;
    if (!rst && blk_out_ch.valid && blk_out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        note_failure($sformatf("unexpected result lo %h hi %h",
                               blk_out_ch.out_word_lo, blk_out_ch.out_word_hi));
      end else begin
        want = expected_blocks.pop_front();
        if (blk_out_ch.out_word_lo !== want.lo || blk_out_ch.out_word_hi !== want.hi) begin
          note_failure($sformatf("result %0d: expected lo %h hi %h, got lo %h hi %h",
                                 blocks_checked, want.lo, want.hi,
                                 blk_out_ch.out_word_lo, blk_out_ch.out_word_hi));
        end
      end
      blocks_checked++;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    blk_out_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  // all-zero key straight out of reset: the schedule is built from reset values
  task automatic test_reset_key();
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_DECRYPT, '0, '0);
    send_block(MODE_ENCRYPT, '1, '1);
    send_block(MODE_DECRYPT, '1, '1);
  endtask

  // published vector, also used to confirm the predictor itself
  task automatic test_known_vector();
    block_t got;
    load_key(KAT_K0, KAT_K1, KAT_K2, KAT_K3);
    got = cipher_block(MODE_ENCRYPT, KAT_PT_LO, KAT_PT_HI);
    if (got.lo !== KAT_CT_LO || got.hi !== KAT_CT_HI) begin
      note_failure($sformatf("predictor gives lo %h hi %h for the known vector",
                             got.lo, got.hi));
    end
    send_block(MODE_ENCRYPT, KAT_PT_LO, KAT_PT_HI);
    send_block(MODE_DECRYPT, KAT_CT_LO, KAT_CT_HI);
  endtask

  // block word extremes in both directions under a random key
  task automatic test_block_extremes();
    load_key($urandom, $urandom, $urandom, $urandom);
    for (int m = 0; m < 2; m++) begin
      send_block(logic'(m), '0, '1);
      send_block(logic'(m), '1, '0);
      send_block(logic'(m), 32'h5555_5555, 32'haaaa_aaaa);
      send_block(logic'(m), 32'h8000_0000, 32'h0000_0001);
    end
  endtask

  // writes above the last key index must leave the schedule untouched
  task automatic test_unknown_index();
    drain_pipeline();
    for (int i = KEY_WORDS; i <= REG_INDEX_TOP; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    send_block(MODE_ENCRYPT, pick_word(), pick_word());
    send_block(MODE_DECRYPT, pick_word(), pick_word());
  endtask

  // an all-ones key, and a lone key word rewrite making the schedule stale
  task automatic test_key_updates();
    load_key('1, '1, '1, '1);
    send_block(MODE_ENCRYPT, pick_word(), pick_word());
    send_block(MODE_DECRYPT, pick_word(), pick_word());
    drain_pipeline();
    write_reg(REG_KEY_WORD_2, 32'h0000_0001);
    send_block(MODE_ENCRYPT, pick_word(), pick_word());
    send_block(MODE_DECRYPT, pick_word(), pick_word());
  endtask

  // random traffic over four idling phases, two key settings per phase
  task automatic test_random_traffic();
    int     sender_idle [4]    = '{0, 84, 0, 23};
    int     receiver_stall [4] = '{0, 0, 84, 23};
    int     target;
    block_t plain;
    block_t sealed;
    logic   mode;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        3:       load_key('1, '1, '1, '1);
        5:       load_key('0, '0, '0, '0);
        6: begin
          drain_pipeline();
          write_reg(REG_KEY_WORD_0, $urandom);
        end
        default: load_key($urandom, $urandom, $urandom, $urandom);
      endcase
      idle_pct  = sender_idle[seg / 2];
      stall_pct = receiver_stall[seg / 2];
      target    = items_sent + RANDOM_ITEMS / SEGMENTS;
      while (items_sent < target) begin
        if ($urandom_range(3) == 0) begin
          mode = logic'($urandom_range(1));
          send_block(mode, pick_word(), pick_word());
        end else begin
          // well-formed pair: transform a block, then undo it
          mode   = logic'($urandom_range(1));
          plain  = '{lo: pick_word(), hi: pick_word()};
          sealed = cipher_block(mode, plain.lo, plain.hi);
          send_block(mode, plain.lo, plain.hi);
          send_block(~mode, sealed.lo, sealed.hi);
        end
      end
    end
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_KEY_WORD_0;
    cfg_data             = '0;
    blk_in_ch.valid      = 1'b0;
    blk_in_ch.mode       = MODE_ENCRYPT;
    blk_in_ch.in_word_lo = '0;
    blk_in_ch.in_word_hi = '0;
    blk_out_ch.ready     = 1'b0;
    for (int i = 0; i < KEY_WORDS; i++) begin
      key_reg[i] = '0;
    end
    sched_valid    = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    cycle_count    = 0;
    fail_count     = 0;
    items_sent     = 0;
    blocks_checked = 0;
    key_loads      = 0;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed part runs with no idling on either side
    test_reset_key();
    test_known_vector();
    test_block_extremes();
    test_unknown_index();
    test_key_updates();
    test_random_traffic();

    drain_pipeline();
    $display("summary: %0d blocks sent, %0d results checked, %0d full key loads",
             items_sent, blocks_checked, key_loads);
    $display("summary: both modes, four idling phases, %0d mismatches", fail_count);
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
